### hw/rtl/ncah_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncah_pkg
// Shared types and constants of the nearest cluster argmin histogram unit.
// ----------------------------------------------------------------------------
package ncah_pkg;

  localparam int unsigned MAX_POINTS_DEF   = 4096;
  localparam int unsigned MAX_CLUSTERS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH      = 4;

  // Position fields are sized for the largest supported parameter values.
  localparam int unsigned PNT_W  = 16;
  localparam int unsigned CLU_W  = 10;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned SEL_W      = 6;
  localparam int unsigned PIDX_W     = 12;
  localparam int unsigned ACL_W      = 6;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned NPTS_W     = 13;
  localparam int unsigned NCLU_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_MAJOR  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_DIST  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } ncah_kind_e;

  typedef struct packed {
    ncah_kind_e               kind;
    logic                     first;
    logic                     last;
    logic                     sel_ok;
    logic [PNT_W-1:0]         point;
    logic [CLU_W-1:0]         cluster;
    logic signed [DIST_W-1:0] distance;
  } ncah_cmd_t;

endpackage

### hw/rtl/ncah_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncah_front
// Holds the configuration, tracks the point and cluster positions of the
// distance stream and turns each accepted item, bar KIND_NONE, into a command for the queue.
// ----------------------------------------------------------------------------
module ncah_front import ncah_pkg::*; #(
  parameter int unsigned MAX_POINTS   = MAX_POINTS_DEF,
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic signed [DIST_W-1:0] distance_i,
  input  logic [SEL_W-1:0]      cluster_select_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output ncah_cmd_t             q_cmd_o
);

  localparam int unsigned NP_W = PNT_W + 1;
  localparam int unsigned NC_W = CLU_W + 1;

  logic [NPTS_W-1:0] num_points_q;
  logic [NCLU_W-1:0] num_clusters_q;
  logic              point_major_q;
  logic [PNT_W-1:0]  pos_p_q, pos_p_d;
  logic [CLU_W-1:0]  pos_c_q, pos_c_d;

  logic [NP_W-1:0] np_ext, n_eff;
  logic [NC_W-1:0] nc_ext, k_eff;
  logic            last_point, last_cluster, accept;
  ncah_kind_e      kind;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign kind        = ncah_kind_e'(kind_i);

  assign np_ext = NP_W'(num_points_q);
  assign nc_ext = NC_W'(num_clusters_q);

  always_comb begin
    if (np_ext == '0) begin
      n_eff = NP_W'(1);
    end else if (np_ext > NP_W'(MAX_POINTS)) begin
      n_eff = NP_W'(MAX_POINTS);
    end else begin
      n_eff = np_ext;
    end
    if (nc_ext == '0) begin
      k_eff = NC_W'(1);
    end else if (nc_ext > NC_W'(MAX_CLUSTERS)) begin
      k_eff = NC_W'(MAX_CLUSTERS);
    end else begin
      k_eff = nc_ext;
    end
  end

  assign last_point   = (NP_W'(pos_p_q) + NP_W'(1)) >= n_eff;
  assign last_cluster = (NC_W'(pos_c_q) + NC_W'(1)) >= k_eff;

  always_comb begin
    pos_p_d = pos_p_q;
    pos_c_d = pos_c_q;
    if (accept && (kind == KIND_DIST)) begin
      if (point_major_q) begin
        if (last_cluster) begin
          pos_c_d = '0;
          pos_p_d = last_point ? '0 : pos_p_q + PNT_W'(1);
        end else begin
          pos_c_d = pos_c_q + CLU_W'(1);
        end
      end else begin
        if (last_point) begin
          pos_p_d = '0;
          pos_c_d = last_cluster ? '0 : pos_c_q + CLU_W'(1);
        end else begin
          pos_p_d = pos_p_q + PNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    q_push_o         = accept && (kind != KIND_NONE);
    q_cmd_o.kind     = kind;
    q_cmd_o.first    = (pos_c_q == '0);
    q_cmd_o.last     = last_cluster;
    q_cmd_o.sel_ok   = NC_W'(cluster_select_i) < NC_W'(MAX_CLUSTERS);
    q_cmd_o.point    = pos_p_q;
    q_cmd_o.cluster  = (kind == KIND_READ) ? CLU_W'(cluster_select_i) : pos_c_q;
    q_cmd_o.distance = distance_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q   <= NPTS_W'(1);
      num_clusters_q <= NCLU_W'(1);
      point_major_q  <= 1'b1;
      pos_p_q        <= '0;
      pos_c_q        <= '0;
    end else begin
      pos_p_q <= pos_p_d;
      pos_c_q <= pos_c_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_NUM_POINTS:   num_points_q   <= cfg_data_i[NPTS_W-1:0];
          CFG_NUM_CLUSTERS: num_clusters_q <= cfg_data_i[NCLU_W-1:0];
          CFG_POINT_MAJOR:  point_major_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### hw/rtl/ncah_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncah_queue
// Small command FIFO that decouples the front end from the execution pipeline.
// ----------------------------------------------------------------------------
module ncah_queue import ncah_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ncah_cmd_t push_cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output ncah_cmd_t head_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ncah_cmd_t      mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [AW:0]    level_q;
  logic           do_push, do_pop;

  assign full_o  = (level_q == (AW+1)'(DEPTH));
  assign valid_o = (level_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - (AW+1)'(1);
      end
    end
  end

endmodule

### hw/rtl/ncah_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncah_back
// Execution pipeline: a per-point best distance stage, a member count stage
// and the output register, with forwarding across each read-modify-write.
// ----------------------------------------------------------------------------
module ncah_back import ncah_pkg::*; #(
  parameter int unsigned MAX_POINTS   = MAX_POINTS_DEF,
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  ncah_cmd_t         q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_count_o,
  output logic [PIDX_W-1:0] point_index_o,
  output logic [ACL_W-1:0]  assigned_cluster_o,
  output logic [CNT_W-1:0]  member_count_o
);

  localparam int unsigned PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  logic signed [DIST_W-1:0] best_dist_mem [MAX_POINTS];
  logic [CW-1:0]            best_clu_mem  [MAX_POINTS];
  logic [CNT_W-1:0]         cnt_mem       [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0]  cnt_vld_q;

  logic                     en, b_adv, b_write, c_write, c_clear, c_emit;

  // Best distance stage.
  logic                     b_valid_q;
  ncah_cmd_t                b_cmd_q;
  logic signed [DIST_W-1:0] rd_dist_q, byp_dist_q, cur_dist, new_dist;
  logic [CW-1:0]            rd_clu_q, byp_clu_q, cur_clu, new_clu, cnt_addr;
  logic                     byp_q;

  // Count stage.
  logic                     c_valid_q;
  ncah_kind_e               c_kind_q;
  logic                     c_last_q, c_sel_ok_q;
  logic [PNT_W-1:0]         c_point_q;
  logic [CW-1:0]            c_clu_q;
  logic [CNT_W-1:0]         cnt_raw_q, cbyp_val_q, cur_cnt, inc_cnt;
  logic                     cnt_hit_q, cbyp_q, czero_q;

  // Output register.
  logic                     out_valid_q, out_is_count_q;
  logic [PIDX_W-1:0]        out_point_q;
  logic [ACL_W-1:0]         out_clu_q;
  logic [CNT_W-1:0]         out_cnt_q;

  assign en      = !out_valid_q || out_ready_i;
  assign q_pop_o = en && q_valid_i;
  assign b_adv   = en && b_valid_q;
  assign b_write = b_adv && (b_cmd_q.kind == KIND_DIST);

  always_comb begin
    cur_dist = byp_q ? byp_dist_q : rd_dist_q;
    cur_clu  = byp_q ? byp_clu_q : rd_clu_q;
    if (b_cmd_q.first) begin
      new_dist = b_cmd_q.distance;
      new_clu  = '0;
    end else if (b_cmd_q.distance < cur_dist) begin
      new_dist = b_cmd_q.distance;
      new_clu  = b_cmd_q.cluster[CW-1:0];
    end else begin
      new_dist = cur_dist;
      new_clu  = cur_clu;
    end
    cnt_addr = (b_cmd_q.kind == KIND_READ) ? b_cmd_q.cluster[CW-1:0] : new_clu;
  end

  always_comb begin
    if (czero_q) begin
      cur_cnt = '0;
    end else if (cbyp_q) begin
      cur_cnt = cbyp_val_q;
    end else if (cnt_hit_q) begin
      cur_cnt = cnt_raw_q;
    end else begin
      cur_cnt = '0;
    end
    inc_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + CNT_W'(1);
    c_write = en && c_valid_q && (c_kind_q == KIND_DIST) && c_last_q;
    c_clear = en && c_valid_q && (c_kind_q == KIND_CLEAR);
    c_emit  = c_valid_q && ((c_kind_q == KIND_READ) ||
                            ((c_kind_q == KIND_DIST) && c_last_q));
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_dist_q <= best_dist_mem[q_head_i.point[PW-1:0]];
      rd_clu_q  <= best_clu_mem[q_head_i.point[PW-1:0]];
    end
    if (b_write) begin
      best_dist_mem[b_cmd_q.point[PW-1:0]] <= new_dist;
      best_clu_mem[b_cmd_q.point[PW-1:0]]  <= new_clu;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      cnt_raw_q <= cnt_mem[cnt_addr];
    end
    if (c_write) begin
      cnt_mem[c_clu_q] <= inc_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_cmd_q    <= q_head_i;
      byp_dist_q <= new_dist;
      byp_clu_q  <= new_clu;
    end
    if (b_adv) begin
      c_kind_q   <= b_cmd_q.kind;
      c_last_q   <= b_cmd_q.last;
      c_sel_ok_q <= b_cmd_q.sel_ok;
      c_point_q  <= b_cmd_q.point;
      c_clu_q    <= cnt_addr;
      cbyp_val_q <= inc_cnt;
    end
    if (en && c_emit) begin
      out_is_count_q <= (c_kind_q == KIND_READ);
      out_point_q    <= (c_kind_q == KIND_READ) ? '0 : PIDX_W'(c_point_q);
      out_clu_q      <= (c_kind_q == KIND_READ) ? '0 : ACL_W'(c_clu_q);
      out_cnt_q      <= ((c_kind_q == KIND_READ) && c_sel_ok_q) ? cur_cnt : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
      cbyp_q      <= 1'b0;
      czero_q     <= 1'b0;
      cnt_hit_q   <= 1'b0;
      cnt_vld_q   <= '0;
    end else begin
      if (en) begin
        b_valid_q   <= q_valid_i;
        c_valid_q   <= b_valid_q;
        out_valid_q <= c_emit;
        byp_q       <= b_write &&
                       (q_head_i.point[PW-1:0] == b_cmd_q.point[PW-1:0]);
      end
      if (b_adv) begin
        cbyp_q    <= c_write && (cnt_addr == c_clu_q);
        czero_q   <= c_clear;
        cnt_hit_q <= cnt_vld_q[cnt_addr];
      end
      if (c_clear) begin
        cnt_vld_q <= '0;
      end else if (c_write) begin
        cnt_vld_q[c_clu_q] <= 1'b1;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign is_count_o         = out_is_count_q;
  assign point_index_o      = out_point_q;
  assign assigned_cluster_o = out_clu_q;
  assign member_count_o     = out_cnt_q;

endmodule

### hw/rtl/nearest_cluster_argmin_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_cluster_argmin_histogram_unit
// K-means assignment step: per-point argmin over streamed distances with a
// per-cluster member histogram.
// ----------------------------------------------------------------------------
// Usage
// The input channel carries items of three kinds: a Q16.16 distance, a read
// of one cluster's member count, or a clear of all counts. Distances arrive
// point by point or cluster by cluster, as the point_major register sets.
// The last distance of a point yields one assignment transfer on the output
// channel, and a count read yields one readout transfer. Registers are to be
// written through the configuration channel only while the unit is idle; the
// unit does not enforce this. Throughput is one item per cycle while the
// receiver does not stall. An accepted item passes through the command queue,
// the best distance stage and the count stage into the output register.
// Reset clears positions and member counts at once and restores the register
// defaults; no clearing pass is needed. When the receiver stalls, the
// pipeline holds and the four-entry queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module nearest_cluster_argmin_histogram_unit import ncah_pkg::*; #(
  parameter int unsigned MAX_POINTS   = MAX_POINTS_DEF,
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic signed [DIST_W-1:0] distance_i,
  input  logic [SEL_W-1:0]         cluster_select_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     is_count_o,
  output logic [PIDX_W-1:0]        point_index_o,
  output logic [ACL_W-1:0]         assigned_cluster_o,
  output logic [CNT_W-1:0]         member_count_o
);

  ncah_cmd_t push_cmd, head_cmd;
  logic      q_push, q_full, q_pop, q_valid;

  ncah_front #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .distance_i      (distance_i),
    .cluster_select_i(cluster_select_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  ncah_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (head_cmd)
  );

  ncah_back #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_head_i          (head_cmd),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .is_count_o        (is_count_o),
    .point_index_o     (point_index_o),
    .assigned_cluster_o(assigned_cluster_o),
    .member_count_o    (member_count_o)
  );

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("Queue reports full while empty.");

  a_readout_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_count_o) |-> (point_index_o == '0 && assigned_cluster_o == '0))
    else $error("Count readout carries assignment fields.");

  a_assign_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_count_o) |-> (member_count_o == '0))
    else $error("Assignment result carries a member count.");

  a_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !q_pop)
    else $error("Queue popped while the output is stalled.");

endmodule

### tb/tb_nearest_cluster_argmin_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_cluster_argmin_histogram_unit
// Self-checking bench for the k-means assignment and member histogram unit.
// A small scoreboard class predicts each point's nearest cluster and the
// per-cluster counts from every accepted transfer. Each output transfer is
// checked field by field against the oldest prediction. The stimulus starts
// with directed ties, extremes and mid-pass register changes. Next come a
// longer run of single-cluster points and random passes in both orders.
// Both channels stall in random bursts, and the receiver also holds off for
// long stretches.
// ----------------------------------------------------------------------------
module tb_nearest_cluster_argmin_histogram_unit;
  import ncah_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1050;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [DIST_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic              is_count;
    logic [PIDX_W-1:0] point_index;
    logic [ACL_W-1:0]  assigned_cluster;
    logic [CNT_W-1:0]  member_count;
  } outcome_t;

  class kmeans_assign_checker;
    int unsigned pts_reg;
    int unsigned clu_reg;
    bit          pt_major;
    int unsigned pnt_pos;
    int unsigned clu_pos;
    int unsigned errors;
    logic signed [DIST_W-1:0] best_dist [MAX_POINTS_DEF];
    logic [ACL_W-1:0]         best_clu [MAX_POINTS_DEF];
    logic [CNT_W-1:0]         member_cnt [MAX_CLUSTERS_DEF];
    outcome_t                 due_outcomes[$];

    function new();
      pts_reg  = 1;
      clu_reg  = 1;
      pt_major = 1'b1;
      pnt_pos  = 0;
      clu_pos  = 0;
      errors   = 0;
      foreach (member_cnt[i]) member_cnt[i] = '0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_points();
      return clamp(pts_reg, MAX_POINTS_DEF);
    endfunction

    function int unsigned eff_clusters();
      return clamp(clu_reg, MAX_CLUSTERS_DEF);
    endfunction

    function int unsigned pending();
      return due_outcomes.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NUM_POINTS:   pts_reg = 32'(data);
        CFG_NUM_CLUSTERS: clu_reg = 32'(data[NCLU_W-1:0]);
        CFG_POINT_MAJOR:  pt_major = data[0];
        default: ;
      endcase
    endfunction

    function void take_item(ncah_kind_e kind, logic signed [DIST_W-1:0] dist_val,
                            logic [SEL_W-1:0] sel);
      outcome_t    o;
      bit          last_c;
      bit          last_p;
      logic [ACL_W-1:0] win;
      o = '0;
      case (kind)
        KIND_CLEAR: begin
          foreach (member_cnt[i]) member_cnt[i] = '0;
        end
        KIND_READ: begin
          o.is_count     = 1'b1;
          o.member_count = member_cnt[sel];
          due_outcomes.push_back(o);
        end
        KIND_DIST: begin
          last_c = (clu_pos + 1 >= eff_clusters());
          last_p = (pnt_pos + 1 >= eff_points());
          if (clu_pos == 0 || dist_val < best_dist[pnt_pos]) begin
            best_dist[pnt_pos] = dist_val;
            best_clu[pnt_pos]  = ACL_W'(clu_pos);
          end
          if (last_c) begin
            win = best_clu[pnt_pos];
            if (member_cnt[win] != '1) member_cnt[win]++;
            o.point_index      = PIDX_W'(pnt_pos);
            o.assigned_cluster = win;
            due_outcomes.push_back(o);
          end
          if (pt_major) begin
            if (last_c) begin
              clu_pos = 0;
              pnt_pos = last_p ? 0 : pnt_pos + 1;
            end else begin
              clu_pos++;
            end
          end else begin
            if (last_p) begin
              pnt_pos = 0;
              clu_pos = last_c ? 0 : clu_pos + 1;
            end else begin
              pnt_pos++;
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_outcome(outcome_t got);
      outcome_t want;
      if (due_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0b point=%0d cluster=%0d members=%0d",
                                  got.is_count, got.point_index, got.assigned_cluster,
                                  got.member_count));
        return;
      end
      want = due_outcomes.pop_front();
      if (got.is_count !== want.is_count)
        report_mismatch($sformatf("is_count %0b, expected %0b", got.is_count, want.is_count));
      if (got.point_index !== want.point_index)
        report_mismatch($sformatf("point_index %0d, expected %0d",
                                  got.point_index, want.point_index));
      if (got.assigned_cluster !== want.assigned_cluster)
        report_mismatch($sformatf("assigned_cluster %0d, expected %0d (point %0d)",
                                  got.assigned_cluster, want.assigned_cluster,
                                  want.point_index));
      if (got.member_count !== want.member_count)
        report_mismatch($sformatf("member_count %0d, expected %0d",
                                  got.member_count, want.member_count));
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [KIND_W-1:0]        kind_i = '0;
  logic signed [DIST_W-1:0] distance_i = '0;
  logic [SEL_W-1:0]         cluster_select_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     is_count_o;
  logic [PIDX_W-1:0]        point_index_o;
  logic [ACL_W-1:0]         assigned_cluster_o;
  logic [CNT_W-1:0]         member_count_o;

  kmeans_assign_checker sb = new();

  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  bit          hold_kick = 1'b0;
  int unsigned stim_count = 0;
  int unsigned quiet_cycles = 0;

  nearest_cluster_argmin_histogram_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .distance_i         (distance_i),
    .cluster_select_i   (cluster_select_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .is_count_o         (is_count_o),
    .point_index_o      (point_index_o),
    .assigned_cluster_o (assigned_cluster_o),
    .member_count_o     (member_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : monitor
    outcome_t seen;
    if (out_valid_o && out_ready_i) begin
      seen = {is_count_o, point_index_o, assigned_cluster_o, member_count_o};
      sb.check_outcome(seen);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_kick) begin
        hold_kick = 1'b0;
        stall_left = $urandom_range(120, 200);
      end else if (stall_left == 0 && out_idle_pct != 0 &&
                   $urandom_range(1, 100) <= out_idle_pct) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(ncah_kind_e kind, logic signed [DIST_W-1:0] dist_val,
                           logic [SEL_W-1:0] sel);
    int unsigned gap;
    if (in_idle_pct != 0 && $urandom_range(1, 100) <= in_idle_pct) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    distance_i       <= dist_val;
    cluster_select_i <= sel;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_item(kind, dist_val, sel);
    if (kind != KIND_NONE) stim_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.note_config(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [DIST_W-1:0] pick_distance(int unsigned style);
    logic signed [DIST_W-1:0] v;
    v = $urandom();
    case (style)
      1: begin
        v = $urandom_range(0, 4);
        v = v - 2;
      end
      2: if ($urandom_range(0, 99) < 85) v = Q_MAX;
      default: if ($urandom_range(0, 9) == 0) v = ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
    endcase
    return v;
  endfunction

  task automatic run_phase(bit quiet);
    int unsigned n_cfg;
    int unsigned k_cfg;
    int unsigned style;
    int unsigned passes;
    int unsigned span;
    int unsigned total;
    int unsigned cut;
    int unsigned squeeze_at;
    bit          pm;
    case ($urandom_range(0, 9))
      0: begin
        n_cfg = 0;
        k_cfg = $urandom_range(1, 8);
      end
      1: begin
        n_cfg = $urandom_range(1, 3);
        k_cfg = ($urandom_range(0, 1) != 0) ? 64 : 127;
      end
      2: begin
        n_cfg = $urandom_range(1, 8);
        k_cfg = 0;
      end
      default: begin
        n_cfg = $urandom_range(1, 8);
        k_cfg = $urandom_range(1, 8);
      end
    endcase
    pm     = 1'($urandom_range(0, 1));
    style  = $urandom_range(0, 3);
    passes = (k_cfg > 8) ? 1 : $urandom_range(1, 3);
    if (quiet) begin
      in_idle_pct  = 0;
      out_idle_pct = 0;
    end else begin
      case ($urandom_range(0, 3))
        0: in_idle_pct = 0;
        1: in_idle_pct = 3;
        2: in_idle_pct = 10;
        default: in_idle_pct = 25;
      endcase
      case ($urandom_range(0, 3))
        0: out_idle_pct = 0;
        1: out_idle_pct = 1;
        2: out_idle_pct = 4;
        default: out_idle_pct = 10;
      endcase
    end
    write_reg(CFG_NUM_POINTS, CFG_DATA_W'(n_cfg));
    write_reg(CFG_NUM_CLUSTERS, {6'($urandom()), NCLU_W'(k_cfg)});
    write_reg(CFG_POINT_MAJOR, {12'($urandom()), pm});
    span  = sb.eff_points() * sb.eff_clusters();
    total = passes * span;
    cut   = (!quiet && span > 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, span - 1)
                                                               : total;
    squeeze_at = (!quiet && total >= 24 && $urandom_range(0, 7) == 0) ? total / 2 : total;
    for (int unsigned i = 0; i < total; i++) begin
      // Mid-pass changes stay within what keeps every visited point written.
      if (i == cut) begin
        if ($urandom_range(0, 1) != 0)
          write_reg(CFG_NUM_CLUSTERS, CFG_DATA_W'($urandom_range(0, 10)));
        else if (sb.pt_major)
          write_reg(CFG_NUM_POINTS, CFG_DATA_W'($urandom_range(0, 10)));
        else
          write_reg(CFG_NUM_POINTS, CFG_DATA_W'($urandom_range(0, sb.eff_points())));
      end
      if (i == squeeze_at) hold_kick = 1'b1;
      if ($urandom_range(0, 99) < 8) begin
        case ($urandom_range(0, 5))
          0:       send_item(KIND_CLEAR, $urandom(), SEL_W'($urandom()));
          1, 2:    send_item(KIND_NONE, $urandom(), SEL_W'($urandom()));
          default: send_item(KIND_READ, $urandom(), SEL_W'($urandom()));
        endcase
      end
      send_item(KIND_DIST, pick_distance(style), SEL_W'($urandom()));
    end
    while (sb.pnt_pos != 0 || sb.clu_pos != 0)
      send_item(KIND_DIST, pick_distance(style), SEL_W'($urandom()));
    send_item(KIND_READ, $urandom(), SEL_W'($urandom_range(0, sb.eff_clusters() - 1)));
  endtask

  initial begin : stimulus
    int unsigned random_base;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: one point, one cluster, point-major order.
    send_item(KIND_DIST, Q_MIN, '1);
    send_item(KIND_READ, '1, '0);
    send_item(KIND_NONE, $urandom(), SEL_W'($urandom()));
    send_item(KIND_DIST, Q_MAX, '0);
    send_item(KIND_CLEAR, '1, '1);
    send_item(KIND_READ, '0, '0);

    write_reg(CFG_SPARE, '1);
    write_reg(CFG_NUM_POINTS, 13'd2);
    write_reg(CFG_NUM_CLUSTERS, 13'd3);
    // Point zero sees only the largest value, then point one ties on the smallest value.
    send_item(KIND_DIST, Q_MAX, '0);
    send_item(KIND_DIST, Q_MAX, '0);
    send_item(KIND_DIST, Q_MAX, '0);
    send_item(KIND_DIST, Q_MAX, '0);
    send_item(KIND_DIST, Q_MIN, '0);
    send_item(KIND_DIST, Q_MIN, '0);
    send_item(KIND_READ, '0, 6'd1);

    // Cluster-major order with a tie on point one.
    write_reg(CFG_POINT_MAJOR, 13'd0);
    write_reg(CFG_NUM_CLUSTERS, 13'd2);
    send_item(KIND_DIST, 32'sh000A_0000, '0);
    send_item(KIND_DIST, -32'sd1, '0);
    send_item(KIND_DIST, -32'sh000A_0000, '0);
    send_item(KIND_DIST, -32'sd1, '0);
    send_item(KIND_READ, '0, '0);

    // Cluster count lowered while point zero sits past the new last position.
    write_reg(CFG_POINT_MAJOR, 13'd1);
    write_reg(CFG_NUM_POINTS, 13'd3);
    write_reg(CFG_NUM_CLUSTERS, 13'd4);
    send_item(KIND_DIST, 32'sd5, '0);
    send_item(KIND_DIST, 32'sd3, '0);
    write_reg(CFG_NUM_CLUSTERS, 13'd2);
    send_item(KIND_DIST, 32'sd1, '0);
    send_item(KIND_DIST, 32'sd0, '0);
    send_item(KIND_DIST, 32'sd0, '0);
    send_item(KIND_DIST, -32'sd5, '0);
    send_item(KIND_DIST, -32'sd6, '0);

    // Clamped cluster count with the winner in the last cluster.
    write_reg(CFG_NUM_POINTS, 13'd1);
    write_reg(CFG_NUM_CLUSTERS, 13'd127);
    repeat (63) send_item(KIND_DIST, '0, SEL_W'($urandom()));
    send_item(KIND_DIST, Q_MIN, SEL_W'($urandom()));
    send_item(KIND_READ, $urandom(), 6'd63);
    send_item(KIND_CLEAR, $urandom(), SEL_W'($urandom()));

    // Two passes over a longer point range with a zero cluster count.
    in_idle_pct  = 2;
    out_idle_pct = 2;
    write_reg(CFG_NUM_POINTS, 13'd128);
    write_reg(CFG_NUM_CLUSTERS, 13'd0);
    for (int unsigned i = 0; i < 256; i++) begin
      if (i == 40 || i == 180) hold_kick = 1'b1;
      send_item(KIND_DIST, pick_distance(0), SEL_W'($urandom()));
    end
    send_item(KIND_READ, $urandom(), '0);
    send_item(KIND_CLEAR, $urandom(), SEL_W'($urandom()));
    send_item(KIND_READ, $urandom(), '0);

    random_base = stim_count;
    hold_kick = 1'b1;
    while (stim_count - random_base < RANDOM_ITEMS) run_phase(1'b0);
    run_phase(1'b1);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
